// File: src/ps2md_pkg.sv
package ps2md_pkg;

  // Input beat: a received mouse byte or a read request
  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [2:0]        status;
    logic [2:0]        buttons;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic signed [3:0] wheel_delta;
  } out_item_t;

  // Decoded packet as stored in the ring
  typedef struct packed {
    logic [2:0]        buttons;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic signed [3:0] wheel_delta;
  } pkt_t;

  typedef enum logic [2:0] {
    ST_PARTIAL  = 3'd0,
    ST_DESYNC   = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_QFULL    = 3'd3,
    ST_QUEUED   = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_RDPKT    = 3'd6
  } status_t;

  // What the back end has to do with a classified beat
  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t status;
    pkt_t    pkt;
  } cmd_t;

  // First-byte flag bits
  localparam int unsigned SYNC_BIT     = 3;
  localparam int unsigned OVF_X_BIT    = 6;
  localparam int unsigned OVF_Y_BIT    = 7;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH   = 4;
  localparam int unsigned CMDQ_AW      = 2;
  localparam int unsigned CMDQ_CW      = 3;

endpackage

// File: src/ps2md_ram.sv
module ps2md_ram import ps2md_pkg::*; #(
  parameter int unsigned WIDTH = 23,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

// File: src/ps2md_front.sv
module ps2md_front import ps2md_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic       wheel_mode_r;
  logic [1:0] byte_pos_r;
  logic [1:0] byte_pos_nxt;
  logic [7:0] partial_r [3];
  logic       fire;
  logic       store_byte;
  logic [1:0] last_pos;
  logic [7:0] b2;
  logic [7:0] flags;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign fire      = in_valid && cmd_ready;
  assign last_pos  = wheel_mode_r ? 2'd3 : 2'd2;
  assign flags     = partial_r[0];
  assign b2        = (byte_pos_r == 2'd2) ? in_data.rx_byte : partial_r[2];

  // Classify the beat and build the packet once the last byte is in
  always_comb begin
    cmd              = '0;
    cmd.op           = OP_REPORT;
    cmd.status       = ST_PARTIAL;
    store_byte       = 1'b0;
    byte_pos_nxt     = byte_pos_r;
    cmd.pkt.buttons     = flags[2:0];
    cmd.pkt.delta_x     = partial_r[1];
    cmd.pkt.delta_y     = 8'd0 - b2;
    cmd.pkt.wheel_delta = wheel_mode_r ? in_data.rx_byte[3:0] : 4'd0;
    if (in_data.func) begin
      cmd.op = OP_POP;
    end else if (byte_pos_r == 2'd0 && !in_data.rx_byte[SYNC_BIT]) begin
      cmd.status = ST_DESYNC;
    end else if (byte_pos_r < last_pos) begin
      store_byte   = 1'b1;
      byte_pos_nxt = byte_pos_r + 2'd1;
    end else begin
      byte_pos_nxt = 2'd0;
      if (flags[OVF_X_BIT] || flags[OVF_Y_BIT]) begin
        cmd.status = ST_OVERFLOW;
      end else begin
        cmd.op     = OP_PUSH;
        cmd.status = ST_QUEUED;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_mode_r <= 1'b0;
      byte_pos_r   <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        wheel_mode_r <= cfg_wr_data;
      end
      if (fire) begin
        byte_pos_r <= byte_pos_nxt;
      end
    end
  end

  // Partial packet bytes
  always_ff @(posedge clk) begin
    if (fire && store_byte) begin
      partial_r[byte_pos_r] <= in_data.rx_byte;
    end
  end

endmodule

// File: src/ps2md_cmdq.sv
module ps2md_cmdq import ps2md_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t               entries_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] head_r;
  logic [CMDQ_AW-1:0] tail_r;
  logic [CMDQ_CW-1:0] count_r;
  logic               push;
  logic               pop;

  assign wr_ready = (count_r != CMDQ_CW'(CMDQ_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_cmd   = entries_r[head_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        tail_r <= tail_r + 1'b1;
      end
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[tail_r] <= wr_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CMDQ_CW'(CMDQ_DEPTH))
    else $error("cmdq count above depth");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r != '0)
    else $error("cmdq lost a pushed beat");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> head_r == tail_r)
    else $error("cmdq empty with pointer gap");
`endif

endmodule

// File: src/ps2md_back.sv
module ps2md_back import ps2md_pkg::*; #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned PW = $clog2(RING_DEPTH);

  logic [PW-1:0]         rd_ptr_r;
  logic [PW-1:0]         wr_ptr_r;
  logic [PW-1:0]         rd_inc;
  logic [PW-1:0]         wr_inc;
  logic                  out_valid_r;
  status_t               status_r;
  status_t               status_nxt;
  logic                  adv;
  logic                  we;
  logic                  re;
  logic [$bits(pkt_t)-1:0] rdata;
  pkt_t                  rd_pkt;

  assign cmd_ready = !out_valid_r || out_ready;
  assign adv       = cmd_valid && cmd_ready;
  assign rd_inc    = (rd_ptr_r == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign wr_inc    = (wr_ptr_r == PW'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;

  // Execute the head command against the ring
  always_comb begin
    status_nxt = cmd.status;
    we         = 1'b0;
    re         = 1'b0;
    case (cmd.op)
      OP_REPORT: status_nxt = cmd.status;
      OP_PUSH: begin
        if (wr_inc == rd_ptr_r) begin
          status_nxt = ST_QFULL;
        end else begin
          status_nxt = ST_QUEUED;
          we         = adv;
        end
      end
      OP_POP: begin
        if (rd_ptr_r == wr_ptr_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_RDPKT;
          re         = adv;
        end
      end
      default: status_nxt = cmd.status;
    endcase
  end

  ps2md_ram #(
    .WIDTH($bits(pkt_t)),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .we     (we),
    .waddr  (wr_ptr_r),
    .wdata  (cmd.pkt),
    .re     (re),
    .raddr  (rd_ptr_r),
    .rdata_r(rdata)
  );

  // Ring pointers and output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (we) begin
        wr_ptr_r <= wr_inc;
      end
      if (re) begin
        rd_ptr_r <= rd_inc;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
    end
  end

  // Packet fields only on a successful read
  assign rd_pkt    = pkt_t'(rdata);
  assign out_valid = out_valid_r;
  always_comb begin
    out_data        = '0;
    out_data.status = status_r;
    if (status_r == ST_RDPKT) begin
      out_data.buttons     = rd_pkt.buttons;
      out_data.delta_x     = rd_pkt.delta_x;
      out_data.delta_y     = rd_pkt.delta_y;
      out_data.wheel_delta = rd_pkt.wheel_delta;
    end
  end

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(we && re && wr_ptr_r == rd_ptr_r))
    else $error("ring read and write at one slot");
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> wr_ptr_r != rd_ptr_r)
    else $error("ring push filled every slot");
  a_rd_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !re |=> $stable(rd_ptr_r))
    else $error("read pointer moved without a pop");
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ptr_r <= PW'(RING_DEPTH - 1) && wr_ptr_r <= PW'(RING_DEPTH - 1))
    else $error("ring pointer out of range");
`endif

endmodule

// File: src/ps2_mouse_packet_decoder_fifo_unit.sv
// PS/2 mouse packet decoder with a packet ring. Each input beat is either a
// byte received from the mouse (func 0) or a request to read one packet
// (func 1); every beat yields exactly one result beat, in order. Bytes are
// gathered into 3-byte packets, or 4-byte packets while wheel_mode is set;
// a first byte without the sync bit is discarded, a packet with an overflow
// bit is dropped, and decoded packets go into a ring of RING_DEPTH slots that
// holds up to RING_DEPTH-1 packets. Throughput is one beat per clock
// sustained in both directions while the output side is not stalled. An
// accepted beat is written into the four-entry command queue; when the back
// end takes it from the head of the queue, the status register and the
// registered read of the ring memory load together to form its result. A
// stalled output holds the back end, and in_ready drops only once the
// command queue is full. wheel_mode is to be written only while idle by
// the user; the block itself does not enforce it.
module ps2_mouse_packet_decoder_fifo_unit import ps2md_pkg::*; #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  // Byte assembly and classification
  ps2md_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cmd_valid  (fq_valid),
    .cmd_ready  (fq_ready),
    .cmd        (fq_cmd)
  );

  // Decoupling queue
  ps2md_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(fq_valid),
    .wr_ready(fq_ready),
    .wr_cmd  (fq_cmd),
    .rd_valid(qb_valid),
    .rd_ready(qb_ready),
    .rd_cmd  (qb_cmd)
  );

  // Ring push/pop and result register
  ps2md_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(qb_valid),
    .cmd_ready(qb_ready),
    .cmd      (qb_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: tb/sv/tb_ps2_mouse_packet_decoder_fifo_unit.sv
module tb_ps2_mouse_packet_decoder_fifo_unit import ps2md_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_SLOTS     = 32;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RAND_BEATS     = 204;
  localparam int unsigned RAND_PHASES    = 6;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_data;

  // Decoder shadow state
  logic        mode_wheel = 1'b0;
  logic [1:0]  byte_pos   = 2'd0;
  logic [7:0]  held_bytes [3];
  pkt_t        ring_mem [RING_SLOTS];
  int unsigned rd_idx     = 0;
  int unsigned wr_idx     = 0;

  out_item_t   due_reports[$];
  out_item_t   want_rep;
  int unsigned errors       = 0;
  int unsigned beats_sent   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned src_gap_max  = 12;
  int unsigned sink_gap_max = 12;
  int unsigned sink_wait    = 0;

  ps2_mouse_packet_decoder_fifo_unit #(
    .RING_DEPTH(RING_SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always #6 clk = ~clk;

  // Decode one accepted beat and advance the shadow state
  function automatic out_item_t mouse_decode(in_item_t beat);
    out_item_t  rep;
    pkt_t       pk;
    logic [1:0] last_pos;
    logic [7:0] third;
    rep = '0;
    last_pos = mode_wheel ? 2'd3 : 2'd2;
    if (beat.func) begin
      if (rd_idx == wr_idx) begin
        rep.status = ST_EMPTY;
      end else begin
        pk = ring_mem[rd_idx];
        rd_idx = (rd_idx + 1) % RING_SLOTS;
        rep.status      = ST_RDPKT;
        rep.buttons     = pk.buttons;
        rep.delta_x     = pk.delta_x;
        rep.delta_y     = pk.delta_y;
        rep.wheel_delta = pk.wheel_delta;
      end
    end else if (byte_pos == 2'd0 && !beat.rx_byte[SYNC_BIT]) begin
      rep.status = ST_DESYNC;
    end else if (byte_pos < last_pos) begin
      held_bytes[byte_pos] = beat.rx_byte;
      byte_pos = byte_pos + 2'd1;
      rep.status = ST_PARTIAL;
    end else begin
      // packet done; after wheel mode was cleared a fourth byte's value is ignored
      third = (byte_pos == 2'd2) ? beat.rx_byte : held_bytes[2];
      byte_pos = 2'd0;
      if (held_bytes[0][OVF_X_BIT] || held_bytes[0][OVF_Y_BIT]) begin
        rep.status = ST_OVERFLOW;
      end else begin
        pk.buttons     = held_bytes[0][2:0];
        pk.delta_x     = held_bytes[1];
        pk.delta_y     = ~third + 8'd1;
        pk.wheel_delta = mode_wheel ? beat.rx_byte[3:0] : 4'd0;
        if ((wr_idx + 1) % RING_SLOTS == rd_idx) begin
          rep.status = ST_QFULL;
        end else begin
          ring_mem[wr_idx] = pk;
          wr_idx = (wr_idx + 1) % RING_SLOTS;
          rep.status = ST_QUEUED;
        end
      end
    end
    return rep;
  endfunction

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endfunction

  // Drive one beat after a random gap and wait for it to be taken
  task automatic send_beat(input logic func, input logic [7:0] rx);
    int unsigned gap;
    in_item_t    beat;
    beat.func    = func;
    beat.rx_byte = rx;
    gap = $urandom_range(src_gap_max, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    due_reports.push_back(mouse_decode(beat));
    beats_sent++;
  endtask

  task automatic request_read();
    send_beat(1'b1, 8'($urandom));
  endtask

  // Length follows the current wheel setting
  task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    send_beat(1'b0, b0);
    send_beat(1'b0, b1);
    send_beat(1'b0, b2);
    if (mode_wheel)
      send_beat(1'b0, b3);
  endtask

  // Sync bit set; overflow bits now and then
  task automatic send_rand_packet(input bit allow_ovf);
    logic [7:0] first;
    first = 8'($urandom);
    first[SYNC_BIT] = 1'b1;
    if (!allow_ovf || $urandom_range(6, 0) != 0) begin
      first[OVF_X_BIT] = 1'b0;
      first[OVF_Y_BIT] = 1'b0;
    end
    send_packet(first, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Hold off input until every due result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_wheel(input logic wheel_on);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= wheel_on;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    mode_wheel = wheel_on;
  endtask

  task automatic test_empty_reads();
    request_read();
    request_read();
  endtask

  task automatic test_three_byte_packets();
    write_wheel(1'b0);
    // desync: first byte without sync bit
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hF7);
    send_packet(8'h0F, 8'h7F, 8'h80, 8'h00);
    send_packet(8'h08, 8'h80, 8'h00, 8'h00);
    send_packet(8'h08, 8'hFF, 8'h01, 8'h00);
    // overflow drops: X, Y, both
    send_packet(8'h48, 8'h00, 8'h00, 8'h00);
    send_packet(8'h88, 8'h01, 8'h01, 8'h00);
    send_packet(8'hFF, 8'hFF, 8'hFF, 8'h00);
    repeat (4) request_read();
  endtask

  task automatic test_wheel_packets();
    write_wheel(1'b1);
    send_packet(8'h09, 8'h01, 8'h7F, 8'h07);
    send_packet(8'h0A, 8'h80, 8'h02, 8'h08);
    send_packet(8'h0C, 8'h00, 8'hFF, 8'hFF);
    send_packet(8'h08, 8'h55, 8'hAA, 8'hF0);
    repeat (5) request_read();
  endtask

  task automatic test_mode_switch_mid_packet();
    // three bytes held in wheel mode, then back to 3-byte packets
    write_wheel(1'b1);
    send_beat(1'b0, 8'h0B);
    send_beat(1'b0, 8'h10);
    send_beat(1'b0, 8'h20);
    write_wheel(1'b0);
    send_beat(1'b0, 8'h55);
    // two bytes held, then the packet grows to four
    send_beat(1'b0, 8'h09);
    send_beat(1'b0, 8'h33);
    write_wheel(1'b1);
    send_beat(1'b0, 8'h44);
    send_beat(1'b0, 8'hF5);
    repeat (2) request_read();
  endtask

  task automatic test_ring_full();
    write_wheel(1'b0);
    repeat (RING_SLOTS + 1) send_rand_packet(1'b0);
    drain();
    repeat (RING_SLOTS) request_read();
  endtask

  task automatic test_random_traffic();
    int unsigned phase_end;
    int unsigned pick;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0, 5: begin src_gap_max = 12; sink_gap_max = 12; end
        1:    begin src_gap_max = 0;  sink_gap_max = 0;  end
        2:    begin src_gap_max = 0;  sink_gap_max = 12; end
        3:    begin src_gap_max = 12; sink_gap_max = 0;  end
        default: begin src_gap_max = 3; sink_gap_max = 3; end
      endcase
      write_wheel(ph % 2 == 0);
      phase_end = beats_sent + RAND_BEATS / RAND_PHASES;
      while (beats_sent < phase_end) begin
        pick = $urandom_range(99, 0);
        if (pick < 40)
          send_rand_packet(1'b1);
        else if (pick < 80)
          request_read();
        else if (pick < 90)
          send_beat(1'b0, 8'($urandom));
        else if (pick < 95)
          repeat ($urandom_range(8, 1)) request_read();
        else
          repeat ($urandom_range(8, 1)) send_rand_packet(1'b1);
      end
    end
  endtask

  // Result side: random stall drawn per beat
  always @(posedge clk) begin
    if (out_valid && out_ready)
      sink_wait = $urandom_range(sink_gap_max, 0);
    else if (sink_wait != 0)
      sink_wait--;
    out_ready <= (sink_wait == 0);
  end

  // Compare each result beat with the oldest due report
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want_rep = due_reports.pop_front();
        check_field("status", int'(want_rep.status), int'(out_data.status));
        check_field("buttons", int'(want_rep.buttons), int'(out_data.buttons));
        check_field("delta_x", int'(want_rep.delta_x), int'(out_data.delta_x));
        check_field("delta_y", int'(want_rep.delta_y), int'(out_data.delta_y));
        check_field("wheel_delta", int'(want_rep.wheel_delta),
                    int'(out_data.wheel_delta));
      end
    end
  end

  // Stall watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_reads();
    test_three_byte_packets();
    test_wheel_packets();
    test_mode_switch_mid_packet();
    test_ring_full();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    if (due_reports.size() != 0)
      $display("%0t: %0d results never arrived", $time, due_reports.size());
    if (errors == 0 && due_reports.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
src/ps2md_pkg.sv
src/ps2md_ram.sv
src/ps2md_front.sv
src/ps2md_cmdq.sv
src/ps2md_back.sv
src/ps2_mouse_packet_decoder_fifo_unit.sv
tb/sv/tb_ps2_mouse_packet_decoder_fifo_unit.sv
